[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file obbsat_chk.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/core/obbsat_pkg.sv]
// Package for the oriented-box separating-axis test core.
// Field widths, vector types and unpack helpers; no dependencies.
`default_nettype none

package obbsat_pkg;

  localparam int CW    = 21;            // center coordinate, Q13.8
  localparam int AW    = 16;            // axis component, Q4.12
  localparam int LW    = 16;            // edge length, Q8.8
  localparam int DW    = CW + 1;        // center difference
  localparam int PPW   = 2 * AW;        // cross partial product
  localparam int LXW   = PPW + 1;       // candidate axis component
  localparam int DPW   = DW + LXW;      // d.L partial product
  localparam int DSW   = DPW + 2;       // d.L sum / magnitude
  localparam int APW   = LXW + AW;      // L.X partial product
  localparam int ASW   = APW + 2;       // L.X sum / magnitude
  localparam int RPW   = ASW + LW;      // radius term
  localparam int FRAC_SH = 13;          // 2^12 axis scale, 2 for the halving
  localparam int CMPW  = DSW + FRAC_SH; // compare width, covers six radius terms
  localparam int NAX   = 15;            // candidate axes
  localparam int NBX   = 6;             // box axes of both boxes
  localparam int NPP   = 6;             // partial products per cross axis
  localparam int NST   = 6;             // pipe stages ahead of the output register

  typedef struct packed {
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } cvec_t;

  typedef struct packed {
    logic signed [AW-1:0] z;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] x;
  } avec_t;

  typedef struct packed {
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] x;
  } dvec_t;

  typedef struct packed {
    logic signed [LXW-1:0] z;
    logic signed [LXW-1:0] y;
    logic signed [LXW-1:0] x;
  } lvec_t;

  function automatic avec_t unpack_axis(input logic [3*AW-1:0] w);
    avec_t v;
    v.x = w[AW-1:0];
    v.y = w[2*AW-1:AW];
    v.z = w[3*AW-1:2*AW];
    return v;
  endfunction

  function automatic cvec_t unpack_center(input logic [3*CW-1:0] w);
    cvec_t v;
    v.x = w[CW-1:0];
    v.y = w[2*CW-1:CW];
    v.z = w[3*CW-1:2*CW];
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/obb_separating_axis_test_core.sv]
// Top level of the oriented-box overlap test (15-axis separating-axis test).
// Depends on obbsat_pkg, obbsat_cross, obbsat_axis.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat carries both boxes A and B:
//   packed centers (signed Q13.8), three axis rows each (signed Q4.12) and
//   full edge lengths (unsigned Q8.8).
//   Output channel (out_valid / out_stall): one beat per input beat, in order,
//   out_overlap = 1 when no axis separates the boxes.
//   Throughput: one beat per cycle, no gaps, unless a held output beat stalls the pipe; every
//   candidate axis has its own projection lane, so nothing is shared between items.
//   Pipeline: 2 front stages for the difference and cross axes, 4 lane stages
//   for multiply, magnitude, radius product and compare, then 1 output
//   register that drives out_valid and out_overlap.
//   Stall: when the output beat is held by out_stall the whole pipe freezes
//   and in_stall rises the same cycle; no beat is lost or repeated.
//   Reset: synchronous, active low; clears the valid bits only, so the pipe
//   comes up empty and in_stall low.
`default_nettype none

module obb_separating_axis_test_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3*obbsat_pkg::CW-1:0]  in_a_center,
  input  logic [3*obbsat_pkg::AW-1:0]  in_a_axis_x,
  input  logic [3*obbsat_pkg::AW-1:0]  in_a_axis_y,
  input  logic [3*obbsat_pkg::AW-1:0]  in_a_axis_z,
  input  logic [3*obbsat_pkg::LW-1:0]  in_a_lengths,
  input  logic [3*obbsat_pkg::CW-1:0]  in_b_center,
  input  logic [3*obbsat_pkg::AW-1:0]  in_b_axis_x,
  input  logic [3*obbsat_pkg::AW-1:0]  in_b_axis_y,
  input  logic [3*obbsat_pkg::AW-1:0]  in_b_axis_z,
  input  logic [3*obbsat_pkg::LW-1:0]  in_b_lengths,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_overlap
);

  logic en;
  logic [obbsat_pkg::NST-1:0] vld_nxt, vld_r;
  logic out_valid_nxt, out_valid_r;
  logic overlap_nxt, overlap_r;

  obbsat_pkg::lvec_t axis [obbsat_pkg::NAX];
  obbsat_pkg::dvec_t d;
  obbsat_pkg::avec_t aa [3];
  obbsat_pkg::avec_t ba [3];
  logic [3*obbsat_pkg::LW-1:0] al, bl;
  logic [obbsat_pkg::NAX-1:0] sep;

  // whole pipe advances unless a finished beat is held at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  obbsat_cross u_cross (
    .clk       (clk),
    .en        (en),
    .a_center  (in_a_center),
    .a_axis_x  (in_a_axis_x),
    .a_axis_y  (in_a_axis_y),
    .a_axis_z  (in_a_axis_z),
    .a_lengths (in_a_lengths),
    .b_center  (in_b_center),
    .b_axis_x  (in_b_axis_x),
    .b_axis_y  (in_b_axis_y),
    .b_axis_z  (in_b_axis_z),
    .b_lengths (in_b_lengths),
    .axis_o    (axis),
    .d_o       (d),
    .aa_o      (aa),
    .ba_o      (ba),
    .al_o      (al),
    .bl_o      (bl)
  );

  // one lane per candidate axis: A faces, B faces, nine cross products
  for (genvar g = 0; g < obbsat_pkg::NAX; g++) begin : g_lane
    obbsat_axis u_axis (
      .clk   (clk),
      .en    (en),
      .l_i   (axis[g]),
      .d_i   (d),
      .aa_i  (aa),
      .ba_i  (ba),
      .al_i  (al),
      .bl_i  (bl),
      .sep_o (sep[g])
    );
  end

  always_comb begin
    vld_nxt       = {vld_r[obbsat_pkg::NST-2:0], in_valid};
    out_valid_nxt = vld_r[obbsat_pkg::NST-1];
    overlap_nxt   = ~|sep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = overlap_r;

endmodule

`default_nettype wire

[rtl/core/obbsat_cross.sv]
// Front stages: unpack, center difference, cross-product axes (2 stages).
// Depends on obbsat_pkg.
`default_nettype none

module obbsat_cross (
  input  logic                         clk,
  input  logic                         en,
  input  logic [3*obbsat_pkg::CW-1:0]  a_center,
  input  logic [3*obbsat_pkg::AW-1:0]  a_axis_x,
  input  logic [3*obbsat_pkg::AW-1:0]  a_axis_y,
  input  logic [3*obbsat_pkg::AW-1:0]  a_axis_z,
  input  logic [3*obbsat_pkg::LW-1:0]  a_lengths,
  input  logic [3*obbsat_pkg::CW-1:0]  b_center,
  input  logic [3*obbsat_pkg::AW-1:0]  b_axis_x,
  input  logic [3*obbsat_pkg::AW-1:0]  b_axis_y,
  input  logic [3*obbsat_pkg::AW-1:0]  b_axis_z,
  input  logic [3*obbsat_pkg::LW-1:0]  b_lengths,
  output obbsat_pkg::lvec_t            axis_o [obbsat_pkg::NAX],
  output obbsat_pkg::dvec_t            d_o,
  output obbsat_pkg::avec_t            aa_o [3],
  output obbsat_pkg::avec_t            ba_o [3],
  output logic [3*obbsat_pkg::LW-1:0]  al_o,
  output logic [3*obbsat_pkg::LW-1:0]  bl_o
);

  obbsat_pkg::cvec_t ca, cb;
  obbsat_pkg::avec_t aa_in [3];
  obbsat_pkg::avec_t ba_in [3];

  // stage 1
  obbsat_pkg::dvec_t d1_nxt, d1_r;
  obbsat_pkg::avec_t aa1_r [3];
  obbsat_pkg::avec_t ba1_r [3];
  logic [3*obbsat_pkg::LW-1:0] al1_r, bl1_r;
  logic signed [obbsat_pkg::PPW-1:0] pp_nxt [9][obbsat_pkg::NPP];
  logic signed [obbsat_pkg::PPW-1:0] pp_r   [9][obbsat_pkg::NPP];

  // stage 2
  obbsat_pkg::lvec_t ax_nxt [obbsat_pkg::NAX];
  obbsat_pkg::lvec_t ax_r   [obbsat_pkg::NAX];
  obbsat_pkg::dvec_t d2_r;
  obbsat_pkg::avec_t aa2_r [3];
  obbsat_pkg::avec_t ba2_r [3];
  logic [3*obbsat_pkg::LW-1:0] al2_r, bl2_r;

  always_comb begin
    ca = obbsat_pkg::unpack_center(a_center);
    cb = obbsat_pkg::unpack_center(b_center);
    aa_in[0] = obbsat_pkg::unpack_axis(a_axis_x);
    aa_in[1] = obbsat_pkg::unpack_axis(a_axis_y);
    aa_in[2] = obbsat_pkg::unpack_axis(a_axis_z);
    ba_in[0] = obbsat_pkg::unpack_axis(b_axis_x);
    ba_in[1] = obbsat_pkg::unpack_axis(b_axis_y);
    ba_in[2] = obbsat_pkg::unpack_axis(b_axis_z);
    d1_nxt.x = obbsat_pkg::DW'(ca.x) - obbsat_pkg::DW'(cb.x);
    d1_nxt.y = obbsat_pkg::DW'(ca.y) - obbsat_pkg::DW'(cb.y);
    d1_nxt.z = obbsat_pkg::DW'(ca.z) - obbsat_pkg::DW'(cb.z);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_nxt[3*i+j][0] = obbsat_pkg::PPW'(aa_in[i].y) * obbsat_pkg::PPW'(ba_in[j].z);
        pp_nxt[3*i+j][1] = obbsat_pkg::PPW'(aa_in[i].z) * obbsat_pkg::PPW'(ba_in[j].y);
        pp_nxt[3*i+j][2] = obbsat_pkg::PPW'(aa_in[i].z) * obbsat_pkg::PPW'(ba_in[j].x);
        pp_nxt[3*i+j][3] = obbsat_pkg::PPW'(aa_in[i].x) * obbsat_pkg::PPW'(ba_in[j].z);
        pp_nxt[3*i+j][4] = obbsat_pkg::PPW'(aa_in[i].x) * obbsat_pkg::PPW'(ba_in[j].y);
        pp_nxt[3*i+j][5] = obbsat_pkg::PPW'(aa_in[i].y) * obbsat_pkg::PPW'(ba_in[j].x);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax_nxt[i].x   = obbsat_pkg::LXW'(aa1_r[i].x);
      ax_nxt[i].y   = obbsat_pkg::LXW'(aa1_r[i].y);
      ax_nxt[i].z   = obbsat_pkg::LXW'(aa1_r[i].z);
      ax_nxt[3+i].x = obbsat_pkg::LXW'(ba1_r[i].x);
      ax_nxt[3+i].y = obbsat_pkg::LXW'(ba1_r[i].y);
      ax_nxt[3+i].z = obbsat_pkg::LXW'(ba1_r[i].z);
    end
    for (int k = 0; k < 9; k++) begin
      ax_nxt[6+k].x = obbsat_pkg::LXW'(pp_r[k][0]) - obbsat_pkg::LXW'(pp_r[k][1]);
      ax_nxt[6+k].y = obbsat_pkg::LXW'(pp_r[k][2]) - obbsat_pkg::LXW'(pp_r[k][3]);
      ax_nxt[6+k].z = obbsat_pkg::LXW'(pp_r[k][4]) - obbsat_pkg::LXW'(pp_r[k][5]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= d1_nxt;
      aa1_r <= aa_in;
      ba1_r <= ba_in;
      al1_r <= a_lengths;
      bl1_r <= b_lengths;
      pp_r  <= pp_nxt;
      ax_r  <= ax_nxt;
      d2_r  <= d1_r;
      aa2_r <= aa1_r;
      ba2_r <= ba1_r;
      al2_r <= al1_r;
      bl2_r <= bl1_r;
    end
  end

  assign axis_o = ax_r;
  assign d_o    = d2_r;
  assign aa_o   = aa2_r;
  assign ba_o   = ba2_r;
  assign al_o   = al2_r;
  assign bl_o   = bl2_r;

endmodule

`default_nettype wire

[rtl/core/obbsat_axis.sv]
// One candidate axis: projections, magnitudes, radius terms, compare (4 stages).
// Depends on obbsat_pkg.
`default_nettype none

module obbsat_axis (
  input  logic                         clk,
  input  logic                         en,
  input  obbsat_pkg::lvec_t            l_i,
  input  obbsat_pkg::dvec_t            d_i,
  input  obbsat_pkg::avec_t            aa_i [3],
  input  obbsat_pkg::avec_t            ba_i [3],
  input  logic [3*obbsat_pkg::LW-1:0]  al_i,
  input  logic [3*obbsat_pkg::LW-1:0]  bl_i,
  output logic                         sep_o
);

  obbsat_pkg::avec_t bx [obbsat_pkg::NBX];
  logic [obbsat_pkg::LW-1:0] ln_in [obbsat_pkg::NBX];

  // stage 3: products
  logic signed [obbsat_pkg::DPW-1:0] dp_nxt [3];
  logic signed [obbsat_pkg::DPW-1:0] dp_r   [3];
  logic signed [obbsat_pkg::APW-1:0] ap_nxt [obbsat_pkg::NBX][3];
  logic signed [obbsat_pkg::APW-1:0] ap_r   [obbsat_pkg::NBX][3];
  logic [obbsat_pkg::LW-1:0] ln3_r [obbsat_pkg::NBX];

  // stage 4: dot sums, magnitudes
  logic signed [obbsat_pkg::DSW-1:0] dsum;
  logic signed [obbsat_pkg::ASW-1:0] asum [obbsat_pkg::NBX];
  logic [obbsat_pkg::DSW-1:0] dm_nxt, dm_r;
  logic [obbsat_pkg::ASW-1:0] am_nxt [obbsat_pkg::NBX];
  logic [obbsat_pkg::ASW-1:0] am_r   [obbsat_pkg::NBX];
  logic [obbsat_pkg::LW-1:0] ln4_r [obbsat_pkg::NBX];

  // stage 5: radius terms
  logic [obbsat_pkg::RPW-1:0] rp_nxt [obbsat_pkg::NBX];
  logic [obbsat_pkg::RPW-1:0] rp_r   [obbsat_pkg::NBX];
  logic [obbsat_pkg::DSW-1:0] dm5_r;

  // stage 6: compare
  logic [obbsat_pkg::CMPW-1:0] rhs, lhs;
  logic sep_nxt, sep_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bx[i]      = aa_i[i];
      bx[3+i]    = ba_i[i];
      ln_in[i]   = al_i[obbsat_pkg::LW*i +: obbsat_pkg::LW];
      ln_in[3+i] = bl_i[obbsat_pkg::LW*i +: obbsat_pkg::LW];
    end
    dp_nxt[0] = obbsat_pkg::DPW'(d_i.x) * obbsat_pkg::DPW'(l_i.x);
    dp_nxt[1] = obbsat_pkg::DPW'(d_i.y) * obbsat_pkg::DPW'(l_i.y);
    dp_nxt[2] = obbsat_pkg::DPW'(d_i.z) * obbsat_pkg::DPW'(l_i.z);
    for (int k = 0; k < obbsat_pkg::NBX; k++) begin
      ap_nxt[k][0] = obbsat_pkg::APW'(l_i.x) * obbsat_pkg::APW'(bx[k].x);
      ap_nxt[k][1] = obbsat_pkg::APW'(l_i.y) * obbsat_pkg::APW'(bx[k].y);
      ap_nxt[k][2] = obbsat_pkg::APW'(l_i.z) * obbsat_pkg::APW'(bx[k].z);
    end
  end

  // magnitude of the most negative value wraps to its correct unsigned bits
  always_comb begin
    dsum = obbsat_pkg::DSW'(dp_r[0]) + obbsat_pkg::DSW'(dp_r[1]) +
           obbsat_pkg::DSW'(dp_r[2]);
    dm_nxt = dsum[obbsat_pkg::DSW-1] ? obbsat_pkg::DSW'(-dsum) : obbsat_pkg::DSW'(dsum);
    for (int k = 0; k < obbsat_pkg::NBX; k++) begin
      asum[k] = obbsat_pkg::ASW'(ap_r[k][0]) + obbsat_pkg::ASW'(ap_r[k][1]) +
                obbsat_pkg::ASW'(ap_r[k][2]);
      am_nxt[k] = asum[k][obbsat_pkg::ASW-1] ? obbsat_pkg::ASW'(-asum[k])
                                            : obbsat_pkg::ASW'(asum[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < obbsat_pkg::NBX; k++) begin
      rp_nxt[k] = obbsat_pkg::RPW'(am_r[k]) * obbsat_pkg::RPW'(ln4_r[k]);
    end
  end

  always_comb begin
    rhs = '0;
    for (int k = 0; k < obbsat_pkg::NBX; k++) begin
      rhs = rhs + obbsat_pkg::CMPW'(rp_r[k]);
    end
    lhs     = obbsat_pkg::CMPW'(dm5_r) << obbsat_pkg::FRAC_SH;
    sep_nxt = lhs > rhs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_r  <= dp_nxt;
      ap_r  <= ap_nxt;
      ln3_r <= ln_in;
      dm_r  <= dm_nxt;
      am_r  <= am_nxt;
      ln4_r <= ln3_r;
      rp_r  <= rp_nxt;
      dm5_r <= dm_r;
      sep_r <= sep_nxt;
    end
  end

  assign sep_o = sep_r;

endmodule

`default_nettype wire

[rtl/core/obbsat_chk.sv]
// Port-level checker for obb_separating_axis_test_core, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module obbsat_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_overlap
);

  // held output beat keeps its value
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_overlap))

  // input is only pushed back by a held output beat
  `ASSERT_CLK(a_stall_src, in_stall |-> out_valid && out_stall)

  // a free output never blocks the input
  `ASSERT_CLK(a_no_block, !out_stall |-> !in_stall)

  // reset leaves the pipe empty
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind obb_separating_axis_test_core obbsat_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_overlap (out_overlap)
);

`default_nettype wire
